// File: hw/rtl/aus_pkg.sv
// shared types and constants of the access unit splitter
// used by the front classifier, the formatter and the top level; no dependencies
package aus_pkg;

	// scan phase of the open frame, one-hot
	typedef enum logic [2:0] {
		PH_SEEK_START = 3'b001,
		PH_SKIP       = 3'b010,
		PH_SEEK_END   = 3'b100
	} phase_t;

	// per-byte frame event flags handed from front to back
	typedef struct packed {
		logic a_valid;   // frame closed by an end code
		logic b_valid;   // final frame of the stream
		logic b_found;   // final frame saw a first slice
	} aus_flags_t;

	localparam int INDEX_BITS      = 32;
	localparam int LEN_BITS        = 32;
	localparam int FRAME_ADDR_BITS = 48;
	localparam int CFG_DATA_BITS   = 64;
	localparam int CFG_ADDR_BITS   = 4;

	localparam logic [LEN_BITS-1:0] LEN_MAX = 32'hFFFF_FFFF;

	// register index, taken from paddr[3]
	localparam logic REG_BASE_ADDRESS = 1'b0;

	// window and scan constants
	localparam logic [3:0] WIN_LEN  = 4'd9;
	localparam logic [2:0] SKIP_LEN = 3'd7;
	localparam logic [7:0] PREFIX_ZERO = 8'h00;
	localparam logic [7:0] PREFIX_ONE  = 8'h01;

	// nal unit types
	localparam logic [4:0] NAL_SLICE      = 5'd1;
	localparam logic [4:0] NAL_IDR        = 5'd5;
	localparam logic [4:0] NAL_SEI        = 5'd6;
	localparam logic [4:0] NAL_SPS        = 5'd7;
	localparam logic [4:0] NAL_PPS        = 5'd8;
	localparam logic [4:0] NAL_SUBSET_SPS = 5'd15;
	localparam logic [4:0] NAL_SLICE_EXT  = 5'd20;

endpackage

// File: hw/rtl/aus_front.sv
// front classifier: byte window, start and end code detection, frame events
// depends on aus_pkg
module aus_front import aus_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_fire,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	output logic                     ev_push,
	output aus_flags_t               ev_flags,
	output logic [POSITION_BITS-1:0] ev_a_start,
	output logic [POSITION_BITS-1:0] ev_a_end,
	output logic [POSITION_BITS-1:0] ev_b_start,
	output logic [POSITION_BITS-1:0] ev_b_end,
	output logic [INDEX_BITS-1:0]    ev_a_index,
	output logic [INDEX_BITS-1:0]    ev_b_index
);

	localparam logic [POSITION_BITS-1:0] WIN_SPAN = POSITION_BITS'(9);

	logic [7:0]               win_q [9];
	logic [7:0]               win_n [9];
	logic [3:0]               fill_q, fill_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [POSITION_BITS-1:0] start_q, start_n;
	logic [POSITION_BITS-1:0] test_pos;
	phase_t                   phase_q, phase_n;
	logic [2:0]               skip_q, skip_n, skip_dec;
	logic [INDEX_BITS-1:0]    cnt_q;
	logic                     hdr_ok, first_slice, end_code, emit_a;
	logic [4:0]               nal;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			win_n[i] = win_q[i+1];
		end
		win_n[8] = data_byte;
	end

	assign fill_n   = (fill_q < WIN_LEN) ? fill_q + 4'd1 : fill_q;
	assign pos_n    = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
	assign test_pos = pos_n - WIN_SPAN;

	assign nal    = win_n[3][4:0];
	assign hdr_ok = (win_n[0] == PREFIX_ZERO) && (win_n[1] == PREFIX_ZERO)
		&& (win_n[2] == PREFIX_ONE);
	assign first_slice = hdr_ok
		&& ((((nal == NAL_IDR) || (nal == NAL_SLICE)) && win_n[4][7])
		|| ((nal == NAL_SLICE_EXT) && win_n[7][7]));
	assign end_code = first_slice || (hdr_ok && ((nal == NAL_SUBSET_SPS)
		|| (nal == NAL_SPS) || (nal == NAL_PPS) || (nal == NAL_SEI)));

	assign skip_dec = (skip_q != 3'd0) ? skip_q - 3'd1 : skip_q;

	always_comb begin
		phase_n = phase_q;
		skip_n  = skip_q;
		start_n = start_q;
		emit_a  = 1'b0;
		if (fill_n == WIN_LEN) begin
			unique case (phase_q)
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 3'd0) begin
						phase_n = PH_SEEK_END;
					end
				end
				PH_SEEK_END: begin
					if (end_code) begin
						emit_a  = 1'b1;
						start_n = test_pos;
						phase_n = PH_SEEK_START;
						if (first_slice) begin
							phase_n = PH_SKIP;
							skip_n  = SKIP_LEN;
						end
					end
				end
				PH_SEEK_START: begin
					if (first_slice) begin
						phase_n = PH_SKIP;
						skip_n  = SKIP_LEN;
					end
				end
				default: begin
					phase_n = PH_SEEK_START;
				end
			endcase
		end
	end

	assign ev_flags.a_valid = emit_a;
	assign ev_flags.b_valid = last_byte;
	assign ev_flags.b_found = (phase_n != PH_SEEK_START);
	assign ev_push    = in_fire && (emit_a || last_byte);
	assign ev_a_start = start_q;
	assign ev_a_end   = test_pos;
	assign ev_b_start = start_n;
	assign ev_b_end   = pos_n;
	assign ev_a_index = cnt_q;
	assign ev_b_index = cnt_q + INDEX_BITS'(emit_a);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			phase_q <= PH_SEEK_START;
			skip_q  <= '0;
			cnt_q   <= '0;
		end else if (in_fire) begin
			if (last_byte) begin
				// stream end: everything but the base address starts afresh
				fill_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				phase_q <= PH_SEEK_START;
				skip_q  <= '0;
				cnt_q   <= '0;
			end else begin
				fill_q  <= fill_n;
				pos_q   <= pos_n;
				start_q <= start_n;
				phase_q <= phase_n;
				skip_q  <= skip_n;
				cnt_q   <= cnt_q + INDEX_BITS'(emit_a);
			end
		end
	end

endmodule

// File: hw/rtl/aus_queue.sv
// small register queue of frame events between classifier and formatter
// no package dependencies
module aus_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

// File: hw/rtl/aus_back.sv
// formatter: turns frame events into address, length and index results
// depends on aus_pkg
module aus_back import aus_pkg::*; #(
	parameter int POSITION_BITS = 32,
	parameter int ADDRESS_BITS  = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ADDRESS_BITS-1:0]  base_address,
	input  logic                     hd_valid,
	input  aus_flags_t               hd_flags,
	input  logic [POSITION_BITS-1:0] hd_a_start,
	input  logic [POSITION_BITS-1:0] hd_a_end,
	input  logic [POSITION_BITS-1:0] hd_b_start,
	input  logic [POSITION_BITS-1:0] hd_b_end,
	input  logic [INDEX_BITS-1:0]    hd_a_index,
	input  logic [INDEX_BITS-1:0]    hd_b_index,
	output logic                     hd_pop,
	input  logic                     m_tready,
	output logic                     m_tvalid,
	output logic [111:0]             m_tdata,
	output logic                     m_tuser,
	output logic                     m_tlast
);

	logic                     m_valid_q;
	logic [111:0]             m_tdata_q;
	logic                     m_tuser_q, m_tlast_q;
	logic                     half_q;
	logic                     take, fire, pick_a, is_last;
	logic [POSITION_BITS-1:0] sel_start, sel_end, diff;
	logic [INDEX_BITS-1:0]    sel_index;
	logic                     sel_found;
	logic [63:0]              diff_wide;
	logic [LEN_BITS-1:0]      length;
	logic [ADDRESS_BITS-1:0]  addr_sum;

	assign take    = !m_valid_q || m_tready;
	assign fire    = hd_valid && take;
	assign pick_a  = hd_flags.a_valid && !half_q;
	assign is_last = !(pick_a && hd_flags.b_valid);
	assign hd_pop  = fire && is_last;

	assign sel_start = pick_a ? hd_a_start : hd_b_start;
	assign sel_end   = pick_a ? hd_a_end   : hd_b_end;
	assign sel_index = pick_a ? hd_a_index : hd_b_index;
	assign sel_found = pick_a ? 1'b1       : hd_flags.b_found;

	// length clamps at zero below the start and saturates at the top
	assign diff      = sel_end - sel_start;
	assign diff_wide = 64'(diff);
	always_comb begin
		if (sel_end < sel_start) begin
			length = '0;
		end else if (diff_wide > 64'(LEN_MAX)) begin
			length = LEN_MAX;
		end else begin
			length = diff_wide[LEN_BITS-1:0];
		end
	end

	assign addr_sum = base_address + ADDRESS_BITS'(sel_start);

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {sel_index, length, FRAME_ADDR_BITS'(addr_sum)};
			m_tuser_q <= sel_found;
			m_tlast_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			half_q    <= 1'b0;
		end else begin
			if (take) begin
				m_valid_q <= hd_valid;
			end
			if (fire) begin
				half_q <= !is_last;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: hw/rtl/h264_access_unit_splitter.sv
// top level of the h.264 annex b access unit splitter
// depends on aus_pkg, aus_front, aus_queue and aus_back
//
// The block takes an Annex B byte stream, one byte per transfer on the slave
// side, and reports each access unit as one transfer on the master side: device
// address (base_address plus start offset), length in bytes, running frame
// index and a flag saying whether a first slice was seen. A position is tested
// once eight later bytes have arrived; a frame is closed by the next SEI, SPS,
// PPS, subset SPS or first slice after its own first slice, and
// the byte marked tlast closes the last frame and restarts the stream. One byte
// is taken every clock cycle while s_tready is high: the classifier decides on
// each byte in the cycle it arrives, and its frame events go through a
// four-entry queue to the formatter, which, while the output is not stalled,
// produces one result per cycle from the queue head into a registered output.
// A byte that closes two frames gives two results from one queue entry;
// s_tready drops only while the queue is full, which needs a long output stall
// or a run of very short frames. base_address sits at APB byte address 0 and
// is to be written only while the block is idle; the block does not enforce it.
module h264_access_unit_splitter import aus_pkg::*; #(
	parameter int POSITION_BITS = 32,
	parameter int ADDRESS_BITS  = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// apb configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	// byte stream in
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] data_byte
	input  logic                     s_tlast,   // last_byte
	// frame descriptors out
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [111:0]             m_tdata,   // [47:0] frame_address,
	                                            // [79:48] frame_length,
	                                            // [111:80] frame_index
	output logic                     m_tuser,   // start_found
	output logic                     m_tlast    // last_of_run
);

	localparam int QUEUE_DEPTH = 4;
	localparam int EV_W = $bits(aus_flags_t) + 4 * POSITION_BITS + 2 * INDEX_BITS;

	logic [ADDRESS_BITS-1:0]  base_q;
	logic                     cfg_write, in_fire;

	// front to queue
	logic                     ev_push;
	aus_flags_t               ev_flags;
	logic [POSITION_BITS-1:0] ev_a_start, ev_a_end, ev_b_start, ev_b_end;
	logic [INDEX_BITS-1:0]    ev_a_index, ev_b_index;
	logic [EV_W-1:0]          ev_word, hd_word;

	// queue to back
	logic                     q_full, hd_valid, hd_pop;
	aus_flags_t               hd_flags;
	logic [POSITION_BITS-1:0] hd_a_start, hd_a_end, hd_b_start, hd_b_end;
	logic [INDEX_BITS-1:0]    hd_a_index, hd_b_index;

	// configuration register, decoded on paddr[3] only
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[3] == REG_BASE_ADDRESS);
	assign prdata    = (paddr[3] == REG_BASE_ADDRESS) ? CFG_DATA_BITS'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_write) begin
			base_q <= pwdata[ADDRESS_BITS-1:0];
		end
	end

	// input transfer whenever the event queue has room
	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	aus_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.data_byte  (s_tdata),
		.last_byte  (s_tlast),
		.ev_push    (ev_push),
		.ev_flags   (ev_flags),
		.ev_a_start (ev_a_start),
		.ev_a_end   (ev_a_end),
		.ev_b_start (ev_b_start),
		.ev_b_end   (ev_b_end),
		.ev_a_index (ev_a_index),
		.ev_b_index (ev_b_index)
	);

	assign ev_word = {ev_flags, ev_a_start, ev_a_end, ev_b_start, ev_b_end,
		ev_a_index, ev_b_index};

	aus_queue #(
		.WIDTH(EV_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.wr_data   (ev_word),
		.pop       (hd_pop),
		.rd_data   (hd_word),
		.full      (q_full),
		.not_empty (hd_valid)
	);

	assign {hd_flags, hd_a_start, hd_a_end, hd_b_start, hd_b_end,
		hd_a_index, hd_b_index} = hd_word;

	aus_back #(
		.POSITION_BITS(POSITION_BITS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_q),
		.hd_valid     (hd_valid),
		.hd_flags     (hd_flags),
		.hd_a_start   (hd_a_start),
		.hd_a_end     (hd_a_end),
		.hd_b_start   (hd_b_start),
		.hd_b_end     (hd_b_end),
		.hd_a_index   (hd_a_index),
		.hd_b_index   (hd_b_index),
		.hd_pop       (hd_pop),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule

// File: hw/rtl/aus_checker.sv
// port-level checks of the access unit splitter, bound to the top level
// no package dependencies
module aus_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic         m_tuser,
	input logic         m_tlast
);

	logic        m_fire;
	logic        pend_q;
	logic [31:0] pend_idx_q;

	assign m_fire = m_tvalid && m_tready;

	// remember the index of a result that is not the last of its byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
		end else if (m_fire) begin
			pend_q     <= !m_tlast;
			pend_idx_q <= m_tdata[111:80];
		end
	end

	// stalled descriptor holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("descriptor changed while stalled");

	// an end-code frame that shares its byte with the final frame carries a start code
	a_end_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser)
		else $error("end-code frame without start code");

	// the final frame after an end-code frame follows it in index
	a_pair_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && pend_q |-> m_tlast && (m_tdata[111:80] == pend_idx_q + 32'd1))
		else $error("second frame of a byte has wrong index");

endmodule

bind h264_access_unit_splitter aus_checker u_aus_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: bench/tb_h264_access_unit_splitter.sv
// self-checking bench for the h.264 access unit splitter: byte stream in, frame descriptors out
// depends on aus_pkg and h264_access_unit_splitter; a scoreboard class predicts every descriptor
module tb_h264_access_unit_splitter;
	import aus_pkg::*;

	localparam int RUN_LIMIT = 3_000_000;   // time units, well beyond the slowest legal run
	localparam int HOLD_CYCLES = 300;       // long output stall that fills the event queue
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_BASE   = {REG_BASE_ADDRESS, 3'b000};
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNUSED = {~REG_BASE_ADDRESS, 3'b000};

	// one expected frame descriptor
	typedef struct {
		logic [FRAME_ADDR_BITS-1:0] addr;
		logic [LEN_BITS-1:0]        len;
		logic [INDEX_BITS-1:0]      idx;
		logic                       found;
		logic                       last;
	} frame_desc_t;

	// one stream byte with its end-of-stream mark
	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	// tracks the scan of the byte stream and holds the frames it predicts
	class access_unit_tracker;
		logic [FRAME_ADDR_BITS-1:0] base_addr;
		logic [7:0]                 win [9];
		int unsigned                fill;
		logic [31:0]                pos;
		logic [31:0]                start_off;
		logic [INDEX_BITS-1:0]      frame_cnt;
		phase_t                     phase;
		logic [2:0]                 skip_left;
		frame_desc_t                pending_frames [$];
		int                         mismatches;

		function new();
			base_addr = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			foreach (win[i]) win[i] = '0;
			fill = 0;
			pos = '0;
			start_off = '0;
			phase = PH_SEEK_START;
			skip_left = '0;
			frame_cnt = '0;
		endfunction

		function bit prefix_ok();
			return win[0] == PREFIX_ZERO && win[1] == PREFIX_ZERO && win[2] == PREFIX_ONE;
		endfunction

		// slice with first_mb set, or a slice extension with the flag in byte 7
		function bit first_slice();
			logic [4:0] t;
			t = win[3][4:0];
			if (!prefix_ok())
				return 1'b0;
			if ((t == NAL_SLICE || t == NAL_IDR) && win[4][7])
				return 1'b1;
			return t == NAL_SLICE_EXT && win[7][7];
		endfunction

		function bit end_code();
			logic [4:0] t;
			t = win[3][4:0];
			if (!prefix_ok())
				return 1'b0;
			if (t == NAL_SEI || t == NAL_SPS || t == NAL_PPS || t == NAL_SUBSET_SPS)
				return 1'b1;
			return first_slice();
		endfunction

		function void seek_slice();
			if (first_slice()) begin
				phase = PH_SKIP;
				skip_left = SKIP_LEN;
			end
		endfunction

		function void close_frame(logic [31:0] end_pos, logic found);
			frame_desc_t d;
			d.addr = base_addr + {{(FRAME_ADDR_BITS-32){1'b0}}, start_off};
			d.len = (end_pos >= start_off) ? end_pos - start_off : '0;
			d.idx = frame_cnt;
			d.found = found;
			d.last = 1'b0;
			pending_frames.insert(pending_frames.size(), d);
			frame_cnt++;
		endfunction

		// one accepted byte: advance the window and queue any frames it closes
		function void take_byte(logic [7:0] b, logic last_b);
			int n_before;
			int i;
			logic [31:0] p;
			n_before = pending_frames.size();
			for (i = 0; i < 8; i++)
				win[i] = win[i+1];
			win[8] = b;
			if (pos != '1)
				pos++;
			if (fill < 9)
				fill++;
			if (fill >= 9) begin
				p = (pos >= 32'd9) ? pos - 32'd9 : '0;
				case (phase)
					PH_SKIP: begin
						if (skip_left > 0)
							skip_left--;
						if (skip_left == 0)
							phase = PH_SEEK_END;
					end
					PH_SEEK_END: begin
						if (end_code()) begin
							close_frame(p, 1'b1);
							start_off = p;
							phase = PH_SEEK_START;
							seek_slice();
						end
					end
					default: begin
						phase = PH_SEEK_START;
						seek_slice();
					end
				endcase
			end
			if (last_b) begin
				close_frame(pos, phase != PH_SEEK_START);
				restart();
			end
			if (pending_frames.size() > n_before)
				pending_frames[pending_frames.size()-1].last = 1'b1;
		endfunction

		function void check_field(string field_name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h got %0h", $time, field_name, want, got);
				mismatches++;
			end
		endfunction

		// one accepted descriptor against the oldest predicted frame
		function void compare_frame(logic [FRAME_ADDR_BITS-1:0] addr, logic [LEN_BITS-1:0] len,
				logic [INDEX_BITS-1:0] idx, logic found, logic last);
			frame_desc_t d;
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected descriptor addr %0h len %0h index %0h", $time,
					addr, len, idx);
				mismatches++;
				return;
			end
			d = pending_frames.pop_front();
			check_field("frame_address", 64'(d.addr), 64'(addr));
			check_field("frame_length", 64'(d.len), 64'(len));
			check_field("frame_index", 64'(d.idx), 64'(idx));
			check_field("start_found", 64'(d.found), 64'(found));
			check_field("last_of_run", 64'(d.last), 64'(last));
		endfunction
	endclass

	// clock, reset and block inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [CFG_DATA_BITS-1:0] pwdata = '0;
	logic s_tvalid = 1'b0;
	logic [7:0] s_tdata = '0;     // [7:0] data_byte
	logic s_tlast = 1'b0;         // last_byte
	logic m_tready = 1'b0;

	logic [CFG_DATA_BITS-1:0] prdata;
	logic pready;
	logic s_tready;
	logic m_tvalid;
	logic [111:0] m_tdata;        // [47:0] frame_address, [79:48] frame_length,
	                              // [111:80] frame_index
	logic m_tuser;                // start_found
	logic m_tlast;                // last_of_run

	access_unit_tracker sb;
	stream_byte_t stream_buf [$];
	logic [7:0] directed_bytes [0:22];
	int sender_idle = 0;          // percent of cycles the byte source holds back
	int recv_stall = 0;           // percent of cycles the descriptor sink stalls
	int hold_left = 0;
	bit hold_req = 1'b0;

	h264_access_unit_splitter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// descriptor sink: random stalls, plus one long hold-off counted here
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// both transfers are taken at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (m_tvalid && m_tready)
				sb.compare_frame(m_tdata[47:0], m_tdata[79:48], m_tdata[111:80], m_tuser,
					m_tlast);
			if (s_tvalid && s_tready)
				sb.take_byte(s_tdata, s_tlast);
		end
	end

	task apb_write(input logic [CFG_ADDR_BITS-1:0] a, input logic [CFG_DATA_BITS-1:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// read base_address back and compare with the tracked copy
	task apb_check_base();
		logic [CFG_DATA_BITS-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_BASE;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.check_field("base_address readback", 64'(sb.base_addr),
			64'(rd[FRAME_ADDR_BITS-1:0]));
	endtask

	task set_base(input logic [FRAME_ADDR_BITS-1:0] value);
		apb_write(ADDR_BASE, {{(CFG_DATA_BITS-FRAME_ADDR_BITS){1'b0}}, value});
		sb.base_addr = value;
		apb_check_base();
	endtask

	// offer one byte, with random gaps before it, and wait for its transfer
	task send_byte(input logic [7:0] d, input logic l);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
	endtask

	task play_stream();
		foreach (stream_buf[i])
			send_byte(stream_buf[i].data, stream_buf[i].last);
	endtask

	// let every predicted frame come out, then the pipeline settle
	task drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function void push_byte(logic [7:0] b);
		stream_byte_t e;
		e.data = b;
		e.last = 1'b0;
		stream_buf.insert(stream_buf.size(), e);
	endfunction

	// well-formed nal sequence with random content, optionally with one byte spoilt
	function void build_nal_stream(bit corrupt);
		int n_nal;
		int plen;
		logic [4:0] nal_t;
		logic [7:0] b;
		logic mark;
		stream_buf.delete();
		n_nal = $urandom_range(1, 7);
		repeat (n_nal) begin
			if ($urandom_range(0, 3) == 0)
				push_byte(PREFIX_ZERO);
			push_byte(PREFIX_ZERO);
			push_byte(PREFIX_ZERO);
			push_byte(PREFIX_ONE);
			case ($urandom_range(0, 9))
				0, 1: nal_t = NAL_SLICE;
				2: nal_t = NAL_IDR;
				3: nal_t = NAL_SLICE_EXT;
				4: nal_t = NAL_SEI;
				5: nal_t = NAL_SPS;
				6: nal_t = NAL_PPS;
				7: nal_t = NAL_SUBSET_SPS;
				default: nal_t = 5'($urandom_range(0, 31));
			endcase
			b = 8'($urandom);
			b[4:0] = nal_t;
			push_byte(b);
			mark = ($urandom_range(0, 3) != 0);
			// first_mb flag sits in byte 4, or byte 7 for the slice extension
			if (nal_t == NAL_SLICE_EXT)
				repeat (3) push_byte(8'($urandom));
			b = 8'($urandom);
			b[7] = mark;
			push_byte(b);
			plen = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
			repeat (plen) push_byte(8'($urandom));
		end
		if (corrupt)
			stream_buf[$urandom_range(0, stream_buf.size() - 1)].data =
				($urandom_range(0, 1) != 0) ? 8'($urandom) : PREFIX_ZERO;
		stream_buf[stream_buf.size() - 1].last = 1'b1;
	endfunction

	// noise biased towards start code bytes; short lengths give sub-window streams
	function void build_noise_stream();
		int n;
		stream_buf.delete();
		n = $urandom_range(1, 40);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: push_byte(PREFIX_ZERO);
				1: push_byte(PREFIX_ONE);
				default: push_byte(8'($urandom));
			endcase
		end
		stream_buf[stream_buf.size() - 1].last = 1'b1;
	endfunction

	task random_phase(input int n_items, input bit pressure);
		int sent;
		int r;
		bit pressed;
		sent = 0;
		pressed = 1'b0;
		while (sent < n_items) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				build_noise_stream();
			else
				build_nal_stream(r == 1);
			play_stream();
			sent += stream_buf.size();
			// long sink hold-off while bytes keep coming
			if (pressure && !pressed && sent >= 100) begin
				hold_req = 1'b1;
				pressed = 1'b1;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		apb_check_base();

		// directed: top base address, one-byte streams, then a short stream with
		// an idr first slice, a slice extension first slice and an sps
		set_base('1);
		directed_bytes = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h80, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h00, 8'h01, 8'h14, 8'h00, 8'h00, 8'h00, 8'h80,
			8'h00, 8'h00, 8'h01, 8'h07, 8'h42, 8'h00, 8'h01};
		stream_buf.delete();
		push_byte(8'hFF);
		stream_buf[0].last = 1'b1;
		push_byte(8'h00);
		stream_buf[1].last = 1'b1;
		foreach (directed_bytes[i])
			push_byte(directed_bytes[i]);
		stream_buf[stream_buf.size() - 1].last = 1'b1;
		play_stream();
		drain();

		// write to an unmapped register must leave base_address alone
		apb_write(ADDR_UNUSED, {$urandom, $urandom});
		apb_check_base();

		set_base(48'({$urandom, $urandom}));
		sender_idle = 26;
		recv_stall = 67;
		random_phase(375, 1'b0);
		drain();

		set_base('0);
		sender_idle = 67;
		recv_stall = 26;
		random_phase(375, 1'b0);
		drain();

		// base near the top of the address range, where frame addresses can wrap
		set_base({32'hFFFF_FFFF, 16'($urandom)});
		sender_idle = 0;
		recv_stall = 0;
		random_phase(400, 1'b1);
		drain();

		if (sb.mismatches == 0 && sb.pending_frames.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("status: fail");
		$finish;
	end

endmodule

// File: h264_access_unit_splitter.f
hw/rtl/aus_pkg.sv
hw/rtl/aus_front.sv
hw/rtl/aus_queue.sv
hw/rtl/aus_back.sv
hw/rtl/h264_access_unit_splitter.sv
hw/rtl/aus_checker.sv
bench/tb_h264_access_unit_splitter.sv
